/* src/imo_pkg.sv */
// Shared constants, types and helpers for the IMU offset moving-average block.
// No dependencies; every other source file except imo_ram imports this package.
package imo_pkg;

  localparam int WIN_LEN    = 8;
  localparam int AXES       = 6;
  localparam int ACC_AXES   = 3;
  localparam int GYRO_AXES  = AXES - ACC_AXES;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + $clog2(WIN_LEN);
  localparam int PROD_W     = SUM_W + SAMPLE_W + 1;
  localparam int DIVIDEND_W = SUM_W + 9;
  // window length is a power of two, so the mean divide is a shift
  localparam int WIN_SH     = $clog2(WIN_LEN);

  localparam int SLOT_W     = $clog2(WIN_LEN);
  localparam int HIST_DEPTH = AXES * WIN_LEN;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int AX_W       = $clog2(AXES);
  localparam int GYRO_IW    = $clog2(GYRO_AXES);

  localparam int MEAN_W     = 24;
  localparam int RAD_W      = 27;
  localparam int RAD_K_W    = 20;
  localparam int RAD_PROD_W = MEAN_W + RAD_K_W;
  // pi/180 in signed Q0.24
  localparam logic signed [RAD_K_W-1:0] RAD_PER_DEG_Q24 = 20'sd292818;

  localparam int CFG_AW     = 5;
  localparam int APB_DW     = 32;
  localparam int REG_IW     = 3;

  localparam logic [REG_IW-1:0] REG_ACC_OFF_X  = 3'd0;
  localparam logic [REG_IW-1:0] REG_ACC_OFF_Y  = 3'd1;
  localparam logic [REG_IW-1:0] REG_ACC_OFF_Z  = 3'd2;
  localparam logic [REG_IW-1:0] REG_GYRO_OFF_X = 3'd3;
  localparam logic [REG_IW-1:0] REG_GYRO_OFF_Y = 3'd4;
  localparam logic [REG_IW-1:0] REG_GYRO_OFF_Z = 3'd5;
  localparam logic [REG_IW-1:0] REG_GYRO_SCALE = 3'd6;

  localparam logic [SAMPLE_W-1:0] ACC_OFF_X_RST = 16'd100;
  localparam logic [SAMPLE_W-1:0] ACC_OFF_Y_RST = 16'hFF9C;
  localparam logic [SAMPLE_W-1:0] GYRO_SCALE_RST = 16'd3996;

  typedef struct packed {
    logic [AXES-1:0][SAMPLE_W-1:0] offset;
    logic [SAMPLE_W-1:0]           scale;
  } cfg_t;

  // raw minus offset, clamped to the signed 16-bit range
  function automatic logic signed [SAMPLE_W-1:0] correct(
    input logic signed [SAMPLE_W-1:0] raw,
    input logic signed [SAMPLE_W-1:0] off
  );
    logic signed [SAMPLE_W:0] diff;
    diff = (SAMPLE_W+1)'(raw) - (SAMPLE_W+1)'(off);
    if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
      correct = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      correct = diff[SAMPLE_W-1:0];
    end
  endfunction

endpackage

/* src/imo_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/imo_cfg.sv */
// APB-style configuration registers: six axis offsets and the gyro scale.
// Depends on imo_pkg.
module imo_cfg import imo_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic              wr;
  logic [REG_IW-1:0] idx;

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset[0] <= ACC_OFF_X_RST;
      cfg.offset[1] <= ACC_OFF_Y_RST;
      cfg.offset[2] <= '0;
      cfg.offset[3] <= '0;
      cfg.offset[4] <= '0;
      cfg.offset[5] <= '0;
      cfg.scale     <= GYRO_SCALE_RST;
    end else if (wr) begin
      case (idx)
        REG_ACC_OFF_X:  cfg.offset[0] <= pwdata[SAMPLE_W-1:0];
        REG_ACC_OFF_Y:  cfg.offset[1] <= pwdata[SAMPLE_W-1:0];
        REG_ACC_OFF_Z:  cfg.offset[2] <= pwdata[SAMPLE_W-1:0];
        REG_GYRO_OFF_X: cfg.offset[3] <= pwdata[SAMPLE_W-1:0];
        REG_GYRO_OFF_Y: cfg.offset[4] <= pwdata[SAMPLE_W-1:0];
        REG_GYRO_OFF_Z: cfg.offset[5] <= pwdata[SAMPLE_W-1:0];
        REG_GYRO_SCALE: cfg.scale     <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ACC_OFF_X:  prdata = APB_DW'(cfg.offset[0]);
      REG_ACC_OFF_Y:  prdata = APB_DW'(cfg.offset[1]);
      REG_ACC_OFF_Z:  prdata = APB_DW'(cfg.offset[2]);
      REG_GYRO_OFF_X: prdata = APB_DW'(cfg.offset[3]);
      REG_GYRO_OFF_Y: prdata = APB_DW'(cfg.offset[4]);
      REG_GYRO_OFF_Z: prdata = APB_DW'(cfg.offset[5]);
      REG_GYRO_SCALE: prdata = APB_DW'(cfg.scale);
      default:        prdata = '0;
    endcase
  end

endmodule

/* src/imo_div.sv */
// Floor division by the window length, one registered shift stage.
// Depends on imo_pkg.
module imo_div import imo_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  output logic                         done,
  output logic signed [MEAN_W-1:0]     quotient
);

  logic signed [DIVIDEND_W-1:0] shifted;

  // arithmetic shift rounds toward minus infinity, as the floor needs
  assign shifted = dividend >>> WIN_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= shifted[MEAN_W-1:0];
    end
  end

endmodule

/* src/imu_offset_moving_average.sv */
// Six-axis IMU offset correction and moving-average filter, top level.
// Depends on imo_pkg, imo_ram, imo_cfg and imo_div.
//
// Each accepted item (three accelerometer and three gyro samples) has its
// per-axis offset removed with 16-bit saturation, replaces the oldest entry
// of an 8-deep window per axis, and produces one result item: the accel
// window means in Q16.8, and for the gyro axes the scaled rate in deg/s
// (Q16.8) and rad/s (Q11.16), all rounded to nearest with ties upward.
// Windows start at zero after reset, so the means ramp up over the first
// eight items. No new item is taken until the previous result is in the
// output register: the history and running sums are read and written back
// through two RAMs, then the axes are handled one at a time (product,
// rounding offset, floor shift by the window length, and the radian scaling
// and its rounding for gyro), and the output register is loaded when free.
// A new item is accepted while the previous result still waits in the
// output register.
module imu_offset_moving_average import imo_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [SAMPLE_W-1:0] accel_x,
  input  logic signed [SAMPLE_W-1:0] accel_y,
  input  logic signed [SAMPLE_W-1:0] accel_z,
  input  logic signed [SAMPLE_W-1:0] rate_x,
  input  logic signed [SAMPLE_W-1:0] rate_y,
  input  logic signed [SAMPLE_W-1:0] rate_z,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [MEAN_W-1:0]  accel_mean_x,
  output logic signed [MEAN_W-1:0]  accel_mean_y,
  output logic signed [MEAN_W-1:0]  accel_mean_z,
  output logic signed [MEAN_W-1:0]  deg_rate_x,
  output logic signed [MEAN_W-1:0]  deg_rate_y,
  output logic signed [MEAN_W-1:0]  deg_rate_z,
  output logic signed [RAD_W-1:0]   rad_rate_x,
  output logic signed [RAD_W-1:0]   rad_rate_y,
  output logic signed [RAD_W-1:0]   rad_rate_z,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MEM  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_PREP = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_RAD  = 8'b0010_0000,
    S_RND  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  cfg_t   cfg;

  logic [AXES-1:0][SAMPLE_W-1:0] sample_q;
  logic                          accept;
  logic                          load_out;

  // history / running-sum read-modify-write
  logic [SLOT_W-1:0]          slot;
  logic                       full;
  logic                       primed;
  logic [AX_W-1:0]            rd_ax;
  logic                       rd_done;
  logic                       rd_issue;
  logic                       wr_vld;
  logic [AX_W-1:0]            wr_ax;
  logic [HIST_AW-1:0]         wr_addr;
  logic [HIST_AW-1:0]         hist_raddr;
  logic signed [SAMPLE_W-1:0] corr;
  logic signed [SAMPLE_W-1:0] c_q;
  logic [SAMPLE_W-1:0]        hist_rdata;
  logic [SUM_W-1:0]           sum_rdata;
  logic signed [SAMPLE_W-1:0] hist_old;
  logic signed [SUM_W-1:0]    sum_old;
  logic signed [SUM_W-1:0]    sum_new;
  logic                       mem_last;
  logic signed [SUM_W-1:0]    sums_q [AXES];

  // per-axis arithmetic
  logic [AX_W-1:0]              calc_ax;
  logic [GYRO_IW-1:0]           gyro_ax;
  logic                         calc_acc;
  logic signed [PROD_W-1:0]     p_q;
  logic signed [PROD_W-1:0]     p_rnd;
  logic signed [DIVIDEND_W-1:0] acc_div;
  logic signed [DIVIDEND_W-1:0] div_in;
  logic                         div_start;
  logic                         div_done;
  logic signed [MEAN_W-1:0]     div_q;
  logic signed [MEAN_W-1:0]     deg_q;
  logic signed [RAD_PROD_W-1:0] prod_q;
  logic signed [RAD_PROD_W-1:0] rad_sum;
  logic signed [MEAN_W-1:0]     accel_res [ACC_AXES];
  logic signed [MEAN_W-1:0]     deg_res [GYRO_AXES];
  logic signed [RAD_W-1:0]      rad_res [GYRO_AXES];

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  imo_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // ---------------- window memories ----------------
  assign rd_issue   = (state == S_MEM) && !rd_done;
  assign hist_raddr = HIST_AW'(int'(rd_ax) * WIN_LEN + int'(slot));
  assign corr       = correct(sample_q[rd_ax], cfg.offset[rd_ax]);
  assign mem_last   = wr_vld && (wr_ax == AX_W'(AXES - 1));

  imo_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (wr_vld),
    .waddr (wr_addr),
    .wdata (c_q),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  imo_ram #(.WIDTH(SUM_W), .DEPTH(AXES)) u_sums (
    .clk   (clk),
    .we    (wr_vld),
    .waddr (wr_ax),
    .wdata (sum_new),
    .raddr (rd_ax),
    .rdata (sum_rdata)
  );

  // slots not yet written since reset read as zero
  always_comb begin
    hist_old = full ? $signed(hist_rdata) : '0;
    sum_old  = primed ? $signed(sum_rdata) : '0;
    sum_new  = sum_old - SUM_W'(hist_old) + SUM_W'(c_q);
  end

  // ---------------- per-axis arithmetic ----------------
  assign calc_acc = (calc_ax < AX_W'(ACC_AXES));
  assign gyro_ax  = GYRO_IW'(calc_ax - AX_W'(ACC_AXES));

  // mean = floor((256*s + floor(W/2)) / W)
  // deg  = floor(((s*scale + 128*W) >> 8) / W)
  always_comb begin
    acc_div = (DIVIDEND_W'(sums_q[calc_ax]) <<< 8) + DIVIDEND_W'(WIN_LEN / 2);
    p_rnd   = p_q + PROD_W'(128 * WIN_LEN);
    div_in  = calc_acc ? acc_div : p_rnd[PROD_W-1:8];
    rad_sum = prod_q + RAD_PROD_W'(32768);
  end

  assign div_start = (state == S_PREP);

  imo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MEM;
      S_MEM:  if (mem_last) state_next = S_MUL;
      S_MUL:  state_next = S_PREP;
      S_PREP: state_next = S_DIV;
      S_DIV: begin
        if (div_done) state_next = calc_acc ? S_MUL : S_RAD;
      end
      S_RAD:  state_next = S_RND;
      S_RND:  state_next = (calc_ax == AX_W'(AXES - 1)) ? S_OUT : S_MUL;
      S_OUT:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wr_vld    <= 1'b0;
      rd_done   <= 1'b1;
      slot      <= '0;
      full      <= 1'b0;
      primed    <= 1'b0;
    end else begin
      state  <= state_next;
      wr_vld <= rd_issue;
      if (accept) begin
        rd_done <= 1'b0;
      end else if (rd_issue && rd_ax == AX_W'(AXES - 1)) begin
        rd_done <= 1'b1;
      end
      if (mem_last) begin
        primed <= 1'b1;
        if (slot == SLOT_W'(WIN_LEN - 1)) begin
          slot <= '0;
          full <= 1'b1;
        end else begin
          slot <= slot + SLOT_W'(1);
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= {rate_z, rate_y, rate_x, accel_z, accel_y, accel_x};
      rd_ax    <= '0;
    end else if (rd_issue) begin
      rd_ax <= rd_ax + AX_W'(1);
    end
    wr_ax   <= rd_ax;
    wr_addr <= hist_raddr;
    c_q     <= corr;
    if (wr_vld) begin
      sums_q[wr_ax] <= sum_new;
    end

    if (mem_last) begin
      calc_ax <= '0;
    end
    if (state == S_MUL) begin
      p_q <= sums_q[calc_ax] * $signed({1'b0, cfg.scale});
    end
    if (state == S_DIV && div_done) begin
      if (calc_acc) begin
        accel_res[calc_ax[GYRO_IW-1:0]] <= div_q;
        calc_ax <= calc_ax + AX_W'(1);
      end else begin
        deg_q            <= div_q;
        deg_res[gyro_ax] <= div_q;
      end
    end
    if (state == S_RAD) begin
      prod_q <= deg_q * RAD_PER_DEG_Q24;
    end
    if (state == S_RND) begin
      rad_res[gyro_ax] <= rad_sum[RAD_W+15:16];
      calc_ax <= calc_ax + AX_W'(1);
    end

    if (load_out) begin
      accel_mean_x <= accel_res[0];
      accel_mean_y <= accel_res[1];
      accel_mean_z <= accel_res[2];
      deg_rate_x   <= deg_res[0];
      deg_rate_y   <= deg_res[1];
      deg_rate_z   <= deg_res[2];
      rad_rate_x   <= rad_res[0];
      rad_rate_y   <= rad_res[1];
      rad_rate_z   <= rad_res[2];
    end
  end

endmodule

/* verif/imu_offset_moving_average_tb.sv */
// Testbench for imu_offset_moving_average: directed table, then random phases
// under several register settings, each result checked against a predictor or a table row.
// Depends on imo_pkg and the RTL under src/.
module imu_offset_moving_average_tb import imo_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS       = 7;
  localparam logic [REG_IW-1:0] REG_NONE = 3'd7;
  localparam int NUM_DIRECTED   = 23;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 63;
  localparam int MAX_WAIT       = 14;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 10;
  localparam longint DEG_TO_RAD_Q24 = 292818;

  typedef logic [AXES-1:0][SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [ACC_AXES-1:0][MEAN_W-1:0]  mean;
    logic [GYRO_AXES-1:0][MEAN_W-1:0] deg;
    logic [GYRO_AXES-1:0][RAD_W-1:0]  rad;
  } filt_out_t;

  typedef struct {
    sample_t   raw;
    bit        typed;
    filt_out_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] accel_x = '0;
  logic signed [SAMPLE_W-1:0] accel_y = '0;
  logic signed [SAMPLE_W-1:0] accel_z = '0;
  logic signed [SAMPLE_W-1:0] rate_x = '0;
  logic signed [SAMPLE_W-1:0] rate_y = '0;
  logic signed [SAMPLE_W-1:0] rate_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [MEAN_W-1:0] accel_mean_x, accel_mean_y, accel_mean_z;
  logic signed [MEAN_W-1:0] deg_rate_x, deg_rate_y, deg_rate_z;
  logic signed [RAD_W-1:0]  rad_rate_x, rad_rate_y, rad_rate_z;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // predictor state
  logic [SAMPLE_W-1:0] cfg_reg [NUM_REGS];
  int win_hist [AXES][WIN_LEN];
  int win_sum [AXES];
  int win_slot;

  filt_out_t pending_q [$];
  dir_row_t  dir_tab [NUM_DIRECTED];
  int mismatches = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;

  imu_offset_moving_average dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
    .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .accel_mean_x(accel_mean_x), .accel_mean_y(accel_mean_y),
    .accel_mean_z(accel_mean_z),
    .deg_rate_x(deg_rate_x), .deg_rate_y(deg_rate_y), .deg_rate_z(deg_rate_z),
    .rad_rate_x(rad_rate_x), .rad_rate_y(rad_rate_y), .rad_rate_z(rad_rate_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // n / d to nearest, ties upward; d > 0
  function automatic longint round_half_up(input longint n, input longint d);
    longint num, den, q;
    num = 2 * n + d;
    den = 2 * d;
    q = num / den;
    if (num % den != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic filt_out_t filter_step(input sample_t raw);
    int c;
    longint deg, rad;
    filt_out_t r;
    for (int a = 0; a < AXES; a++) begin
      c = int'($signed(raw[a])) - int'($signed(cfg_reg[a]));
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      win_sum[a] += c - win_hist[a][win_slot];
      win_hist[a][win_slot] = c;
    end
    win_slot = (win_slot + 1) % WIN_LEN;
    for (int a = 0; a < ACC_AXES; a++)
      r.mean[a] = MEAN_W'(round_half_up(longint'(win_sum[a]) * 256, WIN_LEN));
    for (int g = 0; g < GYRO_AXES; g++) begin
      deg = round_half_up(longint'(win_sum[ACC_AXES + g]) *
                          longint'(cfg_reg[REG_GYRO_SCALE]), WIN_LEN * 256);
      rad = round_half_up(deg * DEG_TO_RAD_Q24, 65536);
      r.deg[g] = MEAN_W'(deg);
      r.rad[g] = RAD_W'(rad);
    end
    return r;
  endfunction

  // called at a falling edge; upper data bits are junk the block must drop
  task automatic cfg_write(input logic [REG_IW-1:0] idx, input logic [SAMPLE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (idx < NUM_REGS) cfg_reg[idx] = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_sample(input sample_t raw, input bit typed, input filt_out_t want);
    int gap;
    filt_out_t pred;
    gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= raw[0];
    accel_y <= raw[1];
    accel_z <= raw[2];
    rate_x <= raw[3];
    rate_y <= raw[4];
    rate_z <= raw[5];
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = filter_step(raw);
    pending_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic void note_mismatch(input string field, input int axis,
                                        input longint want, input longint got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s[%0d] expected %0d, got %0d", $realtime, field, axis, want, got);
  endfunction

  // receiver: holds stall while a drawn countdown runs, counting down only while a result waits
  always @(negedge clk) begin
    out_stall <= (stall_left > 0);
    if (out_valid === 1'b1 && stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    filt_out_t got, want;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      stall_left = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      got.mean = {accel_mean_z, accel_mean_y, accel_mean_x};
      got.deg = {deg_rate_z, deg_rate_y, deg_rate_x};
      got.rad = {rad_rate_z, rad_rate_y, rad_rate_x};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result item with nothing pending", $realtime);
      end else begin
        want = pending_q.pop_front();
        for (int a = 0; a < ACC_AXES; a++)
          if (got.mean[a] !== want.mean[a])
            note_mismatch("accel_mean", a, longint'($signed(want.mean[a])),
                          longint'($signed(got.mean[a])));
        for (int g = 0; g < GYRO_AXES; g++) begin
          if (got.deg[g] !== want.deg[g])
            note_mismatch("deg_rate", g, longint'($signed(want.deg[g])),
                          longint'($signed(got.deg[g])));
          if (got.rad[g] !== want.rad[g])
            note_mismatch("rad_rate", g, longint'($signed(want.rad[g])),
                          longint'($signed(got.rad[g])));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] nv [NUM_REGS];
    sample_t raw;
    int kind;
    filt_out_t none;

    none = '0;
    foreach (cfg_reg[r]) cfg_reg[r] = '0;
    cfg_reg[REG_ACC_OFF_X] = ACC_OFF_X_RST;
    cfg_reg[REG_ACC_OFF_Y] = ACC_OFF_Y_RST;
    cfg_reg[REG_GYRO_SCALE] = GYRO_SCALE_RST;
    foreach (win_hist[a, s]) win_hist[a][s] = 0;
    foreach (win_sum[a]) win_sum[a] = 0;
    win_slot = 0;

    // directed rows, reset offsets in force
    foreach (dir_tab[i]) begin
      dir_tab[i].typed = 1'b0;
      dir_tab[i].want = '0;
    end
    // raw equal to the reset offsets: everything stays zero
    dir_tab[0].raw = {16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd100, 16'sd100};
    dir_tab[0].typed = 1'b1;
    // all zero raw: only the accel offsets show, one eighth of 256 * 100
    dir_tab[1].raw = '0;
    dir_tab[1].typed = 1'b1;
    dir_tab[1].want.mean[0] = -24'sd3200;
    dir_tab[1].want.mean[1] = 24'sd3200;
    // first row: accel x low and y high saturate after the offset; second row stays in range
    dir_tab[2].raw = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
    dir_tab[3].raw = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
    // a full window at each extreme
    for (int i = 4; i < 12; i++) dir_tab[i].raw = {AXES{16'h7FFF}};
    for (int i = 12; i < 20; i++) dir_tab[i].raw = {AXES{16'h8000}};
    dir_tab[20].raw = {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001};
    dir_tab[21].raw = {AXES{16'h5555}};
    dir_tab[22].raw = {AXES{16'hAAAA}};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_sample(dir_tab[i].raw, dir_tab[i].typed, dir_tab[i].want);
    wait_drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = 1'b1;
      case (p)
        0: begin
          nv[REG_ACC_OFF_X] = 16'h7FFF;
          nv[REG_ACC_OFF_Y] = 16'h8000;
          nv[REG_ACC_OFF_Z] = 16'h0000;
          nv[REG_GYRO_OFF_X] = 16'h8000;
          nv[REG_GYRO_OFF_Y] = 16'h7FFF;
          nv[REG_GYRO_OFF_Z] = 16'h0001;
          nv[REG_GYRO_SCALE] = 16'hFFFF;
        end
        1: begin
          foreach (nv[r]) nv[r] = '0;
          idle_on = 1'b0;
        end
        3: begin
          nv[REG_ACC_OFF_X] = 16'h8000;
          nv[REG_ACC_OFF_Y] = 16'h8000;
          nv[REG_ACC_OFF_Z] = 16'h8000;
          nv[REG_GYRO_OFF_X] = 16'h7FFF;
          nv[REG_GYRO_OFF_Y] = 16'h7FFF;
          nv[REG_GYRO_OFF_Z] = 16'h7FFF;
          nv[REG_GYRO_SCALE] = 16'h0001;
        end
        5: begin
          nv[REG_ACC_OFF_X] = ACC_OFF_X_RST;
          nv[REG_ACC_OFF_Y] = ACC_OFF_Y_RST;
          nv[REG_ACC_OFF_Z] = '0;
          nv[REG_GYRO_OFF_X] = '0;
          nv[REG_GYRO_OFF_Y] = '0;
          nv[REG_GYRO_OFF_Z] = '0;
          nv[REG_GYRO_SCALE] = GYRO_SCALE_RST;
        end
        default: begin
          foreach (nv[r]) nv[r] = 16'($urandom);
          idle_on = (p != 4);
        end
      endcase
      for (int r = 0; r < NUM_REGS; r++) cfg_write(REG_IW'(r), nv[r]);
      // a write past the last register must change nothing
      cfg_write(REG_NONE, 16'($urandom));

      repeat (PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        for (int a = 0; a < AXES; a++) begin
          if (kind < 6)
            raw[a] = 16'($urandom);
          else if (kind < 8)
            raw[a] = cfg_reg[a] + 16'($urandom_range(0, 128) - 64);
          else if (kind == 8)
            raw[a] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          else
            raw[a] = (a == 0) ? 16'($urandom) : raw[0];
        end
        send_sample(raw, 1'b0, none);
      end
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
src/imo_pkg.sv
src/imo_ram.sv
src/imo_cfg.sv
src/imo_div.sv
src/imu_offset_moving_average.sv
verif/imu_offset_moving_average_tb.sv
